// ===== sv/balance_turn_torque_controller_assert.svh =====
// Assertion macros shared by the controller modules.
`ifndef BALANCE_TURN_TORQUE_CONTROLLER_ASSERT_SVH
`define BALANCE_TURN_TORQUE_CONTROLLER_ASSERT_SVH

// Check that is switched off while reset is asserted.
`define BTTC_CHECK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that must also hold during reset.
`define BTTC_CHECK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bttc_pkg.sv =====
// Shared types, constants and helpers of the balance and turn torque controller.
package bttc_pkg;

    // Window ring geometry.
    localparam int MAX_WINDOW = 64;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int WIN_W      = 7;
    localparam int POS_W      = (RING_AW + 1 > WIN_W) ? RING_AW + 1 : WIN_W;
    localparam int SUM_W      = 32 + RING_AW;
    localparam int SUM_LO_W   = SUM_W / 2;
    localparam int SUM_HI_W   = SUM_W - SUM_LO_W;

    // Error and product widths.
    localparam int E_W = 34;
    localparam int P_W = E_W + 32;

    // Gain table shape.
    localparam int GAIN_SETS  = 4;
    localparam int GAIN_POS   = 6;
    localparam logic [4:0] GAIN_SLOTS = 5'd24;

    // Modes, same encoding as requests.
    localparam logic [2:0] MODE_SIT     = 3'd0;
    localparam logic [2:0] MODE_STAND   = 3'd1;
    localparam logic [2:0] MODE_BALANCE = 3'd2;
    localparam logic [2:0] MODE_LEFT    = 3'd3;
    localparam logic [2:0] MODE_RIGHT   = 3'd4;
    localparam logic [2:0] MODE_SITDOWN = 3'd5;

    // Word kinds.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_GAIN = 1'b1;

    // Register indexes.
    localparam logic [2:0] REG_WINDOW = 3'd0;
    localparam logic [2:0] REG_IGAIN  = 3'd1;
    localparam logic [2:0] REG_ELIMIT = 3'd2;
    localparam logic [2:0] REG_EXTRA  = 3'd3;
    localparam logic [2:0] REG_TURN   = 3'd4;

    // Fixed-point thresholds and limits.
    localparam logic signed [31:0] UPRIGHT_BOUND = 32'sd3539;
    localparam logic signed [31:0] IMU_SEATED    = -32'sd119275;
    localparam logic [6:0]         UPRIGHT_TICKS = 7'd100;
    localparam logic signed [22:0] SPIN_LIMIT    = 23'sd786432;
    localparam logic signed [22:0] TORQUE_LIMIT  = 23'sd3276800;
    localparam logic signed [22:0] SIT_TORQUE    = 23'sd983040;

    typedef struct packed {
        logic        [WIN_W-1:0] window;
        logic signed [31:0]      igain;
        logic signed [31:0]      elimit;
        logic signed [31:0]      extra;
        logic signed [31:0]      turn;
    } cfg_t;

    typedef struct packed {
        logic               cmd;
        logic        [4:0]  gain_slot;
        logic signed [31:0] gain_value;
        logic        [2:0]  mode_request;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] pitch_rate;
        logic signed [31:0] wheel_position;
        logic signed [31:0] wheel_velocity;
        logic signed [31:0] spin_position;
        logic signed [31:0] spin_velocity;
        logic signed [31:0] imu_angle;
    } item_t;

    typedef struct packed {
        logic [2:0]                    mode;
        logic [GAIN_POS-1:0][E_W-1:0]  e;
        logic [GAIN_POS-1:0][31:0]     k;
        logic                          integ;
        logic [SUM_W-1:0]              rsum;
        logic [31:0]                   igain;
        logic [31:0]                   extra;
    } ctrl_t;

    typedef struct packed {
        logic [2:0]                    mode;
        logic [GAIN_POS-1:0][P_W-1:0]  p;
        logic                          integ;
        logic [SUM_HI_W+31:0]          ph;
        logic [SUM_LO_W+32:0]          pl;
        logic [31:0]                   extra;
    } mult_t;

    // Sign-extend a 32-bit value to the error width.
    function automatic logic signed [E_W-1:0] sx_e(input logic [31:0] v);
        sx_e = {{(E_W-32){v[31]}}, v};
    endfunction

    // Gain set of a table slot (slot divided by six).
    function automatic logic [1:0] slot_set(input logic [4:0] slot);
        if (slot >= 5'd18) begin
            slot_set = 2'd3;
        end else if (slot >= 5'd12) begin
            slot_set = 2'd2;
        end else if (slot >= 5'd6) begin
            slot_set = 2'd1;
        end else begin
            slot_set = 2'd0;
        end
    endfunction

    // Position within a gain set (slot modulo six).
    function automatic logic [2:0] slot_pos(input logic [4:0] slot);
        logic [4:0] base;
        base = 5'(slot_set(slot)) * 5'd6;
        slot_pos = 3'(slot - base);
    endfunction

endpackage

// ===== sv/bttc_ctrl.sv =====
// Mode sequencing, references, gain table and windowed spin ring; first pipeline stage.
`include "balance_turn_torque_controller_assert.svh"
module bttc_ctrl
    import bttc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_vld,
    output logic  in_rdy,
    input  item_t in,
    output logic  c_vld,
    input  logic  c_rdy,
    output ctrl_t c
);

    logic [2:0]               mode_reg;
    logic [6:0]               cnt_reg;
    logic signed [31:0]       refw_reg;
    logic signed [31:0]       refs_reg;
    logic [31:0]              gain_reg [GAIN_POS][GAIN_SETS];
    logic [31:0]              ring_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    ring_vld_reg;
    logic [RING_AW-1:0]       pos_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [31:0]              ent_mem_reg;
    logic                     ent_vld_reg;
    logic                     ent_fwd_reg;
    logic [31:0]              ent_fwd_data_reg;
    logic                     c_vld_reg;
    ctrl_t                    c_reg;

    logic                     fire;
    logic                     tick;
    logic                     gwr;
    logic [1:0]               wset;
    logic [2:0]               wpos;
    logic [2:0]               m1;
    logic [2:0]               m2;
    logic [6:0]               cnt1;
    logic [6:0]               cnt_next;
    logic                     capture;
    logic                     upright;
    logic signed [31:0]       refw_next;
    logic signed [31:0]       refs_next;
    logic signed [E_W-1:0]    rs;
    logic signed [E_W-1:0]    e [GAIN_POS];
    logic [1:0]               set;
    logic                     clear;
    logic                     integ;
    logic [31:0]              v;
    logic [WIN_W-1:0]         w_eff;
    logic [RING_AW-1:0]       pos_eff;
    logic [POS_W-1:0]         pos_inc;
    logic [RING_AW-1:0]       pos_after;
    logic [RING_AW-1:0]       pos_nx;
    logic [RING_AW-1:0]       pf_addr;
    logic [31:0]              old;
    logic [SUM_W-1:0]         sum_new;
    logic                     fwd;
    logic                     vld_pf;
    ctrl_t                    c_next;

    assign in_rdy = !c_vld_reg || c_rdy;
    assign fire   = in_vld && in_rdy;
    assign tick   = fire && (in.cmd == CMD_TICK);
    assign gwr    = fire && (in.cmd == CMD_GAIN) && (in.gain_slot < GAIN_SLOTS);
    assign wset   = slot_set(in.gain_slot);
    assign wpos   = slot_pos(in.gain_slot);

    // Mode request, reference capture and stand-up / sit-down sequencing.
    always_comb begin
        m1 = (in.mode_request <= MODE_SITDOWN) ? in.mode_request : mode_reg;
        capture = (((mode_reg == MODE_LEFT) || (mode_reg == MODE_RIGHT))
                   && (m1 == MODE_BALANCE))
                  || ((mode_reg == MODE_SIT) && (m1 == MODE_STAND));
        refw_next = capture ? in.wheel_position : refw_reg;
        refs_next = capture ? in.spin_position : refs_reg;
        upright = (in.pitch_angle < UPRIGHT_BOUND) && (in.pitch_angle > -UPRIGHT_BOUND);
        cnt1 = cnt_reg + 7'(upright);
        m2 = m1;
        cnt_next = cnt_reg;
        if ((m1 == MODE_SITDOWN) && (in.imu_angle < IMU_SEATED)) begin
            m2 = MODE_SIT;
        end else if (m1 == MODE_STAND) begin
            if (cnt1 > UPRIGHT_TICKS) begin
                m2 = MODE_BALANCE;
                cnt_next = '0;
            end else begin
                cnt_next = cnt1;
            end
        end
    end

    // Errors against the references and the turn offset.
    always_comb begin
        rs = sx_e(refs_next);
        if (m2 == MODE_LEFT) begin
            rs = sx_e(refs_next) + sx_e(cfg.turn);
        end else if (m2 == MODE_RIGHT) begin
            rs = sx_e(refs_next) - sx_e(cfg.turn);
        end
        e[0] = sx_e(in.pitch_angle);
        e[1] = sx_e(in.pitch_rate);
        e[2] = sx_e(in.wheel_position) - sx_e(refw_next);
        e[3] = sx_e(in.wheel_velocity);
        e[4] = sx_e(in.spin_position) - rs;
        e[5] = sx_e(in.spin_velocity);
        set  = 2'(m2 - 3'd1);
    end

    // Ring update: spin error, saturated symmetrically to the largest 32-bit
    // magnitude, replaces the oldest entry.
    always_comb begin
        clear = (m2 == MODE_STAND) || (m2 == MODE_BALANCE);
        integ = ((m2 == MODE_LEFT) || (m2 == MODE_RIGHT)) && (e[4] < sx_e(cfg.elimit));
        if (e[4] > sx_e(32'h7FFF_FFFF)) begin
            v = 32'h7FFF_FFFF;
        end else if (e[4] < -sx_e(32'h7FFF_FFFF)) begin
            v = 32'h8000_0001;
        end else begin
            v = e[4][31:0];
        end
        if (cfg.window == '0) begin
            w_eff = WIN_W'(1);
        end else if (POS_W'(cfg.window) > POS_W'(MAX_WINDOW)) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = cfg.window;
        end
        pos_eff   = (POS_W'(pos_reg) >= POS_W'(w_eff)) ? '0 : pos_reg;
        pos_inc   = POS_W'(pos_eff) + POS_W'(1);
        pos_after = (pos_inc >= POS_W'(w_eff)) ? '0 : pos_inc[RING_AW-1:0];
        old       = ent_fwd_reg ? ent_fwd_data_reg : (ent_vld_reg ? ent_mem_reg : '0);
        sum_new   = sum_reg + {{(SUM_W-32){v[31]}}, v} - {{(SUM_W-32){old[31]}}, old};
    end

    // Address of the ring entry the next word will replace.
    always_comb begin
        pos_nx = pos_reg;
        if (tick && clear) begin
            pos_nx = '0;
        end else if (tick && integ) begin
            pos_nx = pos_after;
        end
        pf_addr = (POS_W'(pos_nx) >= POS_W'(w_eff)) ? '0 : pos_nx;
        fwd     = tick && integ && (pos_eff == pf_addr);
        vld_pf  = !(tick && clear) && ring_vld_reg[pf_addr];
    end

    // Stage register contents.
    always_comb begin
        c_next.mode  = m2;
        for (int i = 0; i < GAIN_POS; i++) begin
            c_next.e[i] = e[i];
            c_next.k[i] = gain_reg[i][set];
        end
        c_next.integ = integ;
        c_next.rsum  = sum_new;
        c_next.igain = cfg.igain;
        c_next.extra = cfg.extra;
    end

    // Control state and ring bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_SIT;
            cnt_reg      <= '0;
            refw_reg     <= '0;
            refs_reg     <= '0;
            ring_vld_reg <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            ent_vld_reg  <= 1'b0;
            ent_fwd_reg  <= 1'b0;
            c_vld_reg    <= 1'b0;
            for (int p = 0; p < GAIN_POS; p++) begin
                for (int s = 0; s < GAIN_SETS; s++) begin
                    gain_reg[p][s] <= '0;
                end
            end
        end else begin
            ent_vld_reg <= vld_pf;
            ent_fwd_reg <= fwd;
            if (gwr) begin
                gain_reg[wpos][wset] <= in.gain_value;
            end
            if (tick) begin
                mode_reg <= m2;
                cnt_reg  <= cnt_next;
                refw_reg <= refw_next;
                refs_reg <= refs_next;
                if (clear) begin
                    ring_vld_reg <= '0;
                    pos_reg      <= '0;
                    sum_reg      <= '0;
                end else if (integ) begin
                    ring_vld_reg[pos_eff] <= 1'b1;
                    pos_reg               <= pos_after;
                    sum_reg               <= sum_new;
                end
            end
            if (tick) begin
                c_vld_reg <= 1'b1;
            end else if (c_rdy) begin
                c_vld_reg <= 1'b0;
            end
        end
    end

    // Ring memory and its prefetch read.
    always_ff @(posedge aclk) begin
        if (tick && integ) begin
            ring_mem[pos_eff] <= v;
        end
        ent_mem_reg      <= ring_mem[pf_addr];
        ent_fwd_data_reg <= v;
        if (tick) begin
            c_reg <= c_next;
        end
    end

    assign c_vld = c_vld_reg;
    assign c     = c_reg;

    `BTTC_CHECK_ALWAYS(a_cnt_bound, aclk, !aresetn || (cnt_reg <= UPRIGHT_TICKS), "upright count overran")
    `BTTC_CHECK(a_clear_sum, aclk, aresetn, tick && clear |=> sum_reg == '0, "ring sum not cleared")
    `BTTC_CHECK(a_gain_silent, aclk, aresetn, fire && (in.cmd == CMD_GAIN) && !c_vld_reg |=> !c_vld_reg, "gain write produced a result")

endmodule

// ===== sv/bttc_mult.sv =====
// Gain products and the split integral product; second pipeline stage.
module bttc_mult
    import bttc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_vld,
    output logic  in_rdy,
    input  ctrl_t c,
    output logic  p_vld,
    input  logic  p_rdy,
    output mult_t p
);

    logic  vld_reg;
    mult_t p_reg;
    mult_t p_next;
    logic  ld;

    assign in_rdy = !vld_reg || p_rdy;
    assign ld     = in_vld && in_rdy;

    // Six state products and the ring sum split into high and low halves.
    always_comb begin
        p_next.mode = c.mode;
        for (int i = 0; i < GAIN_POS; i++) begin
            p_next.p[i] = P_W'($signed(c.e[i]) * $signed(c.k[i]));
        end
        p_next.integ = c.integ;
        p_next.ph    = (SUM_HI_W+32)'($signed(c.rsum[SUM_W-1:SUM_LO_W]) * $signed(c.igain));
        p_next.pl    = (SUM_LO_W+33)'($signed({1'b0, c.rsum[SUM_LO_W-1:0]})
                                      * $signed(c.igain));
        p_next.extra = c.extra;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ld) begin
            vld_reg <= 1'b1;
        end else if (p_rdy) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            p_reg <= p_next;
        end
    end

    assign p_vld = vld_reg;
    assign p     = p_reg;

endmodule

// ===== sv/bttc_mix.sv =====
// Product sums, spin and torque clamps, and the result register.
`include "balance_turn_torque_controller_assert.svh"
module bttc_mix
    import bttc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_vld,
    output logic        in_rdy,
    input  mult_t       p,
    output logic        m_vld,
    input  logic        m_rdy,
    output logic [22:0] left_torque,
    output logic [22:0] right_torque,
    output logic [2:0]  current_mode
);

    localparam int T_W  = P_W - 16;
    localparam int TH_W = T_W + 1;
    localparam int RT_W = SUM_HI_W + 36;
    localparam int SP_W = ((TH_W > RT_W) ? TH_W : RT_W) + 2;
    localparam int LR_W = TH_W + 2;

    logic                    a_vld_reg;
    logic [2:0]              a_mode_reg;
    logic signed [TH_W-1:0]  a_th_reg;
    logic signed [TH_W-1:0]  a_x_reg;
    logic signed [SP_W-1:0]  a_sp_reg;
    logic                    b_vld_reg;
    logic [2:0]              b_mode_reg;
    logic signed [TH_W:0]    b_thx_reg;
    logic signed [22:0]      b_spc_reg;
    logic                    o_vld_reg;
    logic [2:0]              o_mode_reg;
    logic signed [22:0]      o_left_reg;
    logic signed [22:0]      o_right_reg;

    logic                    o_ld;
    logic                    b_ld;
    logic                    a_ld;
    logic signed [T_W-1:0]   t [GAIN_POS];
    logic signed [RT_W-1:0]  rt;
    logic signed [TH_W-1:0]  th_next;
    logic signed [TH_W-1:0]  x_next;
    logic signed [SP_W-1:0]  sp_next;
    logic signed [22:0]      spc_next;
    logic signed [LR_W-1:0]  l_sum;
    logic signed [LR_W-1:0]  r_sum;
    logic signed [22:0]      left_next;
    logic signed [22:0]      right_next;

    // Stage handshakes.
    assign o_ld   = b_vld_reg && (!o_vld_reg || m_rdy);
    assign b_ld   = a_vld_reg && (!b_vld_reg || o_ld);
    assign in_rdy = !a_vld_reg || b_ld;
    assign a_ld   = in_vld && in_rdy;

    // Floor each product to Q16.16 and form the three partial torques.
    always_comb begin
        for (int i = 0; i < GAIN_POS; i++) begin
            t[i] = T_W'($signed(p.p[i]) >>> 16);
        end
        rt = (RT_W'($signed(p.ph)) <<< 3) + RT_W'($signed(p.pl) >>> 16);
        th_next = TH_W'(t[0]) + TH_W'(t[1]);
        x_next  = TH_W'(t[2]) + TH_W'(t[3]);
        sp_next = SP_W'(t[4]) + SP_W'(t[5]) + SP_W'($signed(p.extra));
        if (p.integ) begin
            sp_next = sp_next + SP_W'(rt);
        end
    end

    // Spin clamp.
    always_comb begin
        if (a_sp_reg > SP_W'(SPIN_LIMIT)) begin
            spc_next = SPIN_LIMIT;
        end else if (a_sp_reg < -SP_W'(SPIN_LIMIT)) begin
            spc_next = -SPIN_LIMIT;
        end else begin
            spc_next = 23'(a_sp_reg);
        end
    end

    // Wheel torques, clamped; sitting and sitting down use fixed values.
    always_comb begin
        l_sum = LR_W'(b_thx_reg) + LR_W'(b_spc_reg);
        r_sum = LR_W'(b_thx_reg) - LR_W'(b_spc_reg);
        if (l_sum > LR_W'(TORQUE_LIMIT)) begin
            left_next = TORQUE_LIMIT;
        end else if (l_sum < -LR_W'(TORQUE_LIMIT)) begin
            left_next = -TORQUE_LIMIT;
        end else begin
            left_next = 23'(l_sum);
        end
        if (r_sum > LR_W'(TORQUE_LIMIT)) begin
            right_next = TORQUE_LIMIT;
        end else if (r_sum < -LR_W'(TORQUE_LIMIT)) begin
            right_next = -TORQUE_LIMIT;
        end else begin
            right_next = 23'(r_sum);
        end
        if (b_mode_reg == MODE_SIT) begin
            left_next  = '0;
            right_next = '0;
        end else if (b_mode_reg == MODE_SITDOWN) begin
            left_next  = SIT_TORQUE;
            right_next = SIT_TORQUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            if (a_ld) begin
                a_vld_reg <= 1'b1;
            end else if (b_ld) begin
                a_vld_reg <= 1'b0;
            end
            if (b_ld) begin
                b_vld_reg <= 1'b1;
            end else if (o_ld) begin
                b_vld_reg <= 1'b0;
            end
            if (o_ld) begin
                o_vld_reg <= 1'b1;
            end else if (m_rdy) begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ld) begin
            a_mode_reg <= p.mode;
            a_th_reg   <= th_next;
            a_x_reg    <= x_next;
            a_sp_reg   <= sp_next;
        end
        if (b_ld) begin
            b_mode_reg <= a_mode_reg;
            b_thx_reg  <= (TH_W+1)'(a_th_reg) + (TH_W+1)'(a_x_reg);
            b_spc_reg  <= spc_next;
        end
        if (o_ld) begin
            o_mode_reg  <= b_mode_reg;
            o_left_reg  <= left_next;
            o_right_reg <= right_next;
        end
    end

    assign m_vld        = o_vld_reg;
    assign left_torque  = o_left_reg;
    assign right_torque = o_right_reg;
    assign current_mode = o_mode_reg;

    `BTTC_CHECK(a_sit_zero, aclk, aresetn, o_vld_reg && (o_mode_reg == MODE_SIT) |-> (o_left_reg == '0) && (o_right_reg == '0), "sitting mode drove torque")

endmodule

// ===== sv/balance_turn_torque_controller.sv =====
// Top level: configuration registers, input register and the controller pipeline.
// A result passes six register stages after its word is accepted.
// Throughput: one word per cycle while the result side is ready; gain-write words give no result.
// The window ring entry for the next word is prefetched into a register, so ticks follow back to back.
// Reset (aresetn low, synchronous) clears mode, references, counts, gains and the ring.
// Configuration registers reset to window 16 and all other values zero.
module balance_turn_torque_controller
    import bttc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input words.
    input  logic         s_tvalid,
    output logic         s_tready,
    // gain_slot, gain_value, mode_request, pitch_angle, pitch_rate, wheel_position,
    // wheel_velocity, spin_position, spin_velocity, imu_angle
    input  logic [263:0] s_tdata,
    // cmd
    input  logic         s_tuser,
    // Result words.
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_torque, right_torque, current_mode, zero fill
    output logic [55:0]  m_tdata
);

    cfg_t        cfg_reg;
    logic        in_vld_reg;
    item_t       in_reg;
    item_t       in_next;
    logic        wr;
    logic        ctrl_rdy;
    logic        c_vld;
    logic        c_rdy;
    ctrl_t       c;
    logic        p_vld;
    logic        p_rdy;
    mult_t       p;
    logic [22:0] left_torque;
    logic [22:0] right_torque;
    logic [2:0]  current_mode;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window <= WIN_W'(16);
            cfg_reg.igain  <= '0;
            cfg_reg.elimit <= '0;
            cfg_reg.extra  <= '0;
            cfg_reg.turn   <= '0;
        end else if (wr) begin
            case (paddr[4:2])
                REG_WINDOW: cfg_reg.window <= pwdata[WIN_W-1:0];
                REG_IGAIN:  cfg_reg.igain  <= pwdata;
                REG_ELIMIT: cfg_reg.elimit <= pwdata;
                REG_EXTRA:  cfg_reg.extra  <= pwdata;
                REG_TURN:   cfg_reg.turn   <= pwdata;
                default: ;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        case (paddr[4:2])
            REG_WINDOW: prdata = 32'(cfg_reg.window);
            REG_IGAIN:  prdata = cfg_reg.igain;
            REG_ELIMIT: prdata = cfg_reg.elimit;
            REG_EXTRA:  prdata = cfg_reg.extra;
            REG_TURN:   prdata = cfg_reg.turn;
            default:    prdata = '0;
        endcase
    end

    // Unpack the input word.
    always_comb begin
        in_next.cmd            = s_tuser;
        in_next.gain_slot      = s_tdata[4:0];
        in_next.gain_value     = s_tdata[36:5];
        in_next.mode_request   = s_tdata[39:37];
        in_next.pitch_angle    = s_tdata[71:40];
        in_next.pitch_rate     = s_tdata[103:72];
        in_next.wheel_position = s_tdata[135:104];
        in_next.wheel_velocity = s_tdata[167:136];
        in_next.spin_position  = s_tdata[199:168];
        in_next.spin_velocity  = s_tdata[231:200];
        in_next.imu_angle      = s_tdata[263:232];
    end

    // Input register.
    assign s_tready = !in_vld_reg || ctrl_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (ctrl_rdy) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= in_next;
        end
    end

    bttc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_vld  (in_vld_reg),
        .in_rdy  (ctrl_rdy),
        .in      (in_reg),
        .c_vld   (c_vld),
        .c_rdy   (c_rdy),
        .c       (c)
    );

    bttc_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (c_vld),
        .in_rdy  (c_rdy),
        .c       (c),
        .p_vld   (p_vld),
        .p_rdy   (p_rdy),
        .p       (p)
    );

    bttc_mix u_mix (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_vld       (p_vld),
        .in_rdy       (p_rdy),
        .p            (p),
        .m_vld        (m_tvalid),
        .m_rdy        (m_tready),
        .left_torque  (left_torque),
        .right_torque (right_torque),
        .current_mode (current_mode)
    );

    assign m_tdata = {7'b0, current_mode, right_torque, left_torque};

endmodule

// ===== dv/balance_turn_torque_controller_tb.sv =====
// Testbench for the balance and turn torque controller: stream stimulus and result checking.
`timescale 1ns / 1ps

// Predicts controller results and checks them in order.
class torque_predictor;
    logic [6:0]         win;
    logic signed [63:0] igain, elimit, extra, turn;
    logic [2:0]         mode, prev_mode;
    logic signed [63:0] ref_wheel, ref_spin;
    int                 upright;
    logic signed [63:0] gains[24];
    logic signed [63:0] ring[64];
    int                 rpos;
    logic signed [63:0] rsum;
    logic [55:0]        pending[$];
    int                 errors;

    function new();
        win = 7'd16; igain = 0; elimit = 0; extra = 0; turn = 0;
        mode = 0; prev_mode = 0; ref_wheel = 0; ref_spin = 0; upright = 0;
        foreach (gains[i]) gains[i] = 0;
        foreach (ring[i]) ring[i] = 0;
        rpos = 0; rsum = 0; errors = 0;
    endfunction

    // Apply one register write.
    function void write_reg(int idx, logic [31:0] v);
        case (idx)
            bttc_pkg::REG_WINDOW: win = v[6:0];
            bttc_pkg::REG_IGAIN:  igain = $signed(v);
            bttc_pkg::REG_ELIMIT: elimit = $signed(v);
            bttc_pkg::REG_EXTRA:  extra = $signed(v);
            bttc_pkg::REG_TURN:   turn = $signed(v);
            default: ;
        endcase
    endfunction

    // Floored Q16.16 product; fits in 128 bits with room to spare.
    function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] g);
        logic signed [127:0] p;
        p = 128'(a) * 128'(g);
        return 64'(p >>> 16);
    endfunction

    function logic signed [63:0] clip(logic signed [63:0] v, logic signed [63:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Note one accepted input word and queue its expected result, if any.
    function void note_word(bttc_pkg::item_t it);
        logic signed [63:0] s[6], e[6];
        logic signed [63:0] ul, ur, th, x, sp, rs, imu, v;
        logic [55:0]        word;
        int w, set;
        if (it.cmd == bttc_pkg::CMD_GAIN) begin
            if (it.gain_slot < 24) gains[it.gain_slot] = it.gain_value;
            return;
        end
        s[0] = it.pitch_angle; s[1] = it.pitch_rate; s[2] = it.wheel_position;
        s[3] = it.wheel_velocity; s[4] = it.spin_position; s[5] = it.spin_velocity;
        imu = it.imu_angle;
        if (it.mode_request <= 5) mode = it.mode_request;
        if (((prev_mode == bttc_pkg::MODE_LEFT || prev_mode == bttc_pkg::MODE_RIGHT) &&
             mode == bttc_pkg::MODE_BALANCE) ||
            (prev_mode == bttc_pkg::MODE_SIT && mode == bttc_pkg::MODE_STAND)) begin
            ref_wheel = s[2]; ref_spin = s[4];
        end
        if (mode == bttc_pkg::MODE_SITDOWN && imu < -119275) begin
            mode = bttc_pkg::MODE_SIT;
        end else if (mode == bttc_pkg::MODE_STAND) begin
            if (s[0] < 3539 && s[0] > -3539) upright++;
            if (upright > 100) begin
                mode = bttc_pkg::MODE_BALANCE; upright = 0;
            end
        end
        if (mode == bttc_pkg::MODE_SIT) begin
            ul = 0; ur = 0;
        end else if (mode == bttc_pkg::MODE_SITDOWN) begin
            ul = 15 * 65536; ur = ul;
        end else begin
            rs = ref_spin;
            if (mode == bttc_pkg::MODE_LEFT) rs += turn;
            if (mode == bttc_pkg::MODE_RIGHT) rs -= turn;
            if (mode == bttc_pkg::MODE_STAND || mode == bttc_pkg::MODE_BALANCE) begin
                foreach (ring[i]) ring[i] = 0;
                rpos = 0; rsum = 0;
            end
            set = mode - 1;
            for (int i = 0; i < 6; i++) e[i] = s[i];
            e[2] -= ref_wheel;
            e[4] -= rs;
            th = qmul(e[0], gains[set*6]) + qmul(e[1], gains[set*6+1]);
            x  = qmul(e[2], gains[set*6+2]) + qmul(e[3], gains[set*6+3]);
            sp = qmul(e[4], gains[set*6+4]) + qmul(e[5], gains[set*6+5]);
            if ((mode == bttc_pkg::MODE_LEFT || mode == bttc_pkg::MODE_RIGHT) &&
                e[4] < elimit) begin
                v = clip(e[4], 64'sd2147483647);
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                w = win;
                if (w < 1) w = 1;
                if (w > 64) w = 64;
                if (rpos >= w) rpos = 0;
                rsum += v - ring[rpos];
                ring[rpos] = v;
                rpos++;
                if (rpos >= w) rpos = 0;
                sp += qmul(rsum, igain);
            end
            sp = clip(sp + extra, 12 * 65536);
            ul = clip(th + x + sp, 50 * 65536);
            ur = clip(th + x - sp, 50 * 65536);
        end
        prev_mode = mode;
        word = {7'd0, mode, ur[22:0], ul[22:0]};
        pending = {pending, word};
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(logic [55:0] got);
        logic [55:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[22:0] !== want[22:0])
            $display("%0t: left_torque expected %h actual %h", $time, want[22:0], got[22:0]);
        if (got[45:23] !== want[45:23])
            $display("%0t: right_torque expected %h actual %h", $time, want[45:23], got[45:23]);
        if (got[48:46] !== want[48:46])
            $display("%0t: current_mode expected %0d actual %0d", $time, want[48:46], got[48:46]);
        if (got[48:0] !== want[48:0]) errors++;
    endfunction
endclass

module balance_turn_torque_controller_tb;
    import bttc_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [263:0] s_tdata = 0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [55:0]  m_tdata;

    torque_predictor model = new();
    bit     hold_sink = 0;
    int     cycles = 0;

    balance_turn_torque_controller dut (.*);

    // Clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check results as they are accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) model.check_result(m_tdata);
    end

    // Result side: random stalls, plus a long hold-off when requested.
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_sink = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            if (cycles % 3000 < 600) gap = 0;
            m_tready <= (gap == 0);
            if (gap > 0) repeat (gap - 1) @(posedge aclk);
        end
    end

    // Register write over the configuration port.
    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        model.write_reg(idx, v);
    endtask

    // Send one input word, with a random gap first.
    task automatic send_word(item_t it);
        int gap;
        gap = ($urandom_range(0, 12) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 1);
        if (cycles % 3000 < 600) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.imu_angle, it.spin_velocity, it.spin_position, it.wheel_velocity,
                     it.wheel_position, it.pitch_rate, it.pitch_angle, it.mode_request,
                     it.gain_value, it.gain_slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model.note_word(it);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (model.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_q(int span);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    function automatic item_t tick(logic [2:0] req);
        item_t it;
        it.cmd = CMD_TICK;
        it.gain_slot = 5'($urandom); it.gain_value = $urandom;
        it.mode_request = req;
        it.pitch_angle = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7076) - 3538
                                                     : rnd_q(200000);
        it.pitch_rate = rnd_q(300000);
        it.wheel_position = rnd_q(300000);
        it.wheel_velocity = rnd_q(300000);
        it.spin_position = rnd_q(300000);
        it.spin_velocity = rnd_q(300000);
        it.imu_angle = ($urandom_range(0, 3) == 0) ? -119276 + $urandom_range(0, 2)
                                                   : rnd_q(200000);
        return it;
    endfunction

    function automatic item_t gain_word(logic [4:0] slot, logic [31:0] v);
        item_t it;
        it = tick(3'd6);
        it.cmd = CMD_GAIN; it.gain_slot = slot; it.gain_value = v;
        return it;
    endfunction

    // Stimulus.
    initial begin
        item_t it;
        int    r;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: gains, bad slot, each mode and the extremes.
        for (int i = 0; i < 24; i++)
            send_word(gain_word(5'(i), $urandom_range(0, 262144) - 131072));
        send_word(gain_word(5'd31, 32'h7FFF_FFFF));
        foreach (model.gains[i]) ; // table reset values are already mirrored
        for (int m = 0; m < 8; m++) send_word(tick(3'(m)));
        it = tick(MODE_STAND); it.pitch_angle = 32'h7FFF_FFFF; send_word(it);
        it = tick(MODE_LEFT); it.spin_position = 32'h8000_0000; send_word(it);
        it = tick(MODE_SITDOWN); it.imu_angle = -119276; send_word(it);
        drain();

        // Random phases under several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_WINDOW, ph == 0 ? 0 : ph == 1 ? 127 : ph == 2 ? 64 :
                      ph == 3 ? 1 : $urandom_range(2, 63));
            reg_write(REG_IGAIN, ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 :
                      $urandom_range(0, 40000) - 20000);
            reg_write(REG_ELIMIT, ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 :
                      $urandom_range(0, 600000) - 100000);
            reg_write(REG_EXTRA, ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 :
                      $urandom_range(0, 200000) - 100000);
            reg_write(REG_TURN, ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 :
                      $urandom_range(0, 200000) - 100000);
            if (ph == 3) hold_sink = 1;
            // A stand-up run long enough to promote, then turning sequences.
            if (ph == 4) begin
                send_word(tick(MODE_SIT));
                send_word(tick(MODE_STAND));
                for (int i = 0; i < 105; i++) begin
                    it = tick(3'd6); it.pitch_angle = $urandom_range(0, 7076) - 3538;
                    send_word(it);
                end
            end
            for (int i = 0; i < 45; i++) begin
                r = $urandom_range(0, 19);
                if (r == 0) send_word(gain_word(5'($urandom), $urandom));
                else if (r < 4) send_word(tick(3'($urandom_range(0, 7))));
                else if (r < 10) send_word(tick(3'($urandom_range(3, 4))));
                else send_word(tick(3'(6 + $urandom_range(0, 1))));
            end
            drain();
        end

        if (model.errors == 0 && model.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
